FILE: rtl/hbs_pkg.sv
// Shared types, codes and constants of the heightfield bilinear sampler.
package hbs_pkg;

   // Item codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_LENGTH = 2'd1;

   // Item queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Q8.8 one, and the fixed y term of the unnormalized normal squared
   localparam logic [8:0]  Q8_ONE   = 9'd256;
   localparam logic [31:0] Y_SQ     = 32'h0001_0000;
   localparam logic [33:0] LEN_BIAS = 34'h0_0001_0000;

   typedef struct packed {
      logic        is_query;
      logic        wr_ok;
      logic [8:0]  col0;
      logic [8:0]  col1;
      logic [8:0]  row0;
      logic [8:0]  row1;
      logic [7:0]  fs;
      logic [7:0]  ft;
      logic [15:0] wdata;
   } hbs_entry_type;

   typedef struct packed {
      logic [8:0] idx;
      logic [7:0] frac;
   } hbs_loc_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_MAC,
      BK_NORM
   } hbs_bk_state_type;

   typedef enum logic [1:0] {
      NM_IDLE,
      NM_DIV,
      NM_SQRT
   } hbs_nm_state_type;

endpackage

FILE: rtl/hbs_queue.sv
// Short item queue between the front and back parts.
module hbs_queue import hbs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  hbs_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output hbs_entry_type head
);

   hbs_entry_type entry_ff [QUEUE_DEPTH];
   logic [$clog2(QUEUE_DEPTH)-1:0] wptr_ff, wptr_in;
   logic [$clog2(QUEUE_DEPTH)-1:0] rptr_ff, rptr_in;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] count_ff, count_in;

   assign full      = (count_ff == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/hbs_front.sv
// Front part: config registers, item accept and cell classification.
module hbs_front import hbs_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_LENGTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [8:0]           csr_wdata,
   input  logic                 start,
   input  logic                 queue_full,
   input  logic                 req_cmd,
   input  logic [7:0]           req_col,
   input  logic [7:0]           req_row,
   input  logic signed [15:0]   req_height_value,
   input  logic signed [16:0]   req_pos_x,
   input  logic signed [16:0]   req_pos_z,
   output logic                 push,
   output hbs_entry_type        push_entry
);

   localparam logic [8:0] WIDTH_RST  = (MAX_WIDTH < 256)  ? 9'(MAX_WIDTH)  : 9'd256;
   localparam logic [8:0] LENGTH_RST = (MAX_LENGTH < 256) ? 9'(MAX_LENGTH) : 9'd256;

   logic [8:0] grid_width_ff, grid_width_in;
   logic [8:0] grid_length_ff, grid_length_in;
   hbs_loc_type loc_s, loc_t;

   function automatic logic [8:0] sat(input logic [8:0] v, input int hi);
      logic [8:0] r;
      if (v == 9'd0) begin
         r = 9'd1;
      end else if (int'(v) > hi) begin
         r = 9'(hi);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Shift by half the grid, then clamp below zero and past the last cell.
   function automatic hbs_loc_type locate(input logic [16:0] pos, input logic [8:0] n);
      logic [20:0] s;
      hbs_loc_type r;
      s = {{4{pos[16]}}, pos} + {5'd0, n[8:1], 8'd0};
      if (s[20]) begin
         r.idx  = 9'd0;
         r.frac = 8'd0;
      end else if (s[19:8] >= {3'd0, n}) begin
         r.idx  = n - 9'd1;
         r.frac = 8'd0;
      end else begin
         r.idx  = s[16:8];
         r.frac = s[7:0];
      end
      return r;
   endfunction

   function automatic logic [8:0] neighbor(input logic [8:0] i, input logic [8:0] n);
      logic [9:0] nx;
      nx = {1'b0, i} + 10'd1;
      return (nx < {1'b0, n}) ? nx[8:0] : i;
   endfunction

   assign csr_ready = 1'b1;
   assign push      = start && !queue_full;
   assign loc_s     = locate(req_pos_x, grid_width_ff);
   assign loc_t     = locate(req_pos_z, grid_length_ff);

   always_comb begin
      push_entry.is_query = (req_cmd == CMD_QUERY);
      push_entry.wr_ok    = (int'(req_col) < MAX_WIDTH) && (int'(req_row) < MAX_LENGTH);
      push_entry.wdata    = req_height_value;
      if (req_cmd == CMD_QUERY) begin
         push_entry.col0 = loc_s.idx;
         push_entry.col1 = neighbor(loc_s.idx, grid_width_ff);
         push_entry.row0 = loc_t.idx;
         push_entry.row1 = neighbor(loc_t.idx, grid_length_ff);
         push_entry.fs   = loc_s.frac;
         push_entry.ft   = loc_t.frac;
      end else begin
         push_entry.col0 = {1'b0, req_col};
         push_entry.col1 = {1'b0, req_col};
         push_entry.row0 = {1'b0, req_row};
         push_entry.row1 = {1'b0, req_row};
         push_entry.fs   = 8'd0;
         push_entry.ft   = 8'd0;
      end
   end

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_length_in = grid_length_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRID_WIDTH:  grid_width_in  = sat(csr_wdata, MAX_WIDTH);
            CSR_GRID_LENGTH: grid_length_in = sat(csr_wdata, MAX_LENGTH);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= WIDTH_RST;
         grid_length_ff <= LENGTH_RST;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_length_ff <= grid_length_in;
      end
   end

endmodule

FILE: rtl/hbs_norm.sv
// Iterative unit: floor(sqrt(floor(sq * 2^28 / len2))), one bit per cycle.
module hbs_norm import hbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] sq,
   input  logic [33:0] len2,
   output logic        done,
   output logic [14:0] root
);

   hbs_nm_state_type state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [33:0] rem_ff, rem_in;
   logic [33:0] d_ff, d_in;
   logic        lsb_ff, lsb_in;
   logic [29:0] q_ff, q_in;
   logic [17:0] srem_ff, srem_in;
   logic [14:0] root_ff, root_in;
   logic        done_ff, done_in;
   logic [34:0] t;
   logic [19:0] sr;
   logic [19:0] trial;

   assign done = done_ff;
   assign root = root_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      d_in     = d_ff;
      lsb_in   = lsb_ff;
      q_in     = q_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      done_in  = 1'b0;
      t        = {rem_ff, (cnt_ff == 5'd28) ? lsb_ff : 1'b0};
      sr       = {srem_ff, q_ff[29:28]};
      trial    = {3'd0, root_ff, 2'b01};
      case (state_ff)
         NM_IDLE: begin
            if (start) begin
               // numerator is sq << 28; its top part is sq >> 1
               rem_in   = {3'd0, sq[31:1]};
               d_in     = len2;
               lsb_in   = sq[0];
               q_in     = '0;
               cnt_in   = 5'd28;
               state_in = NM_DIV;
            end
         end
         NM_DIV: begin
            if (t >= {1'b0, d_ff}) begin
               rem_in = 34'(t - {1'b0, d_ff});
               q_in   = {q_ff[28:0], 1'b1};
            end else begin
               rem_in = t[33:0];
               q_in   = {q_ff[28:0], 1'b0};
            end
            if (cnt_ff == 5'd0) begin
               cnt_in   = 5'd14;
               srem_in  = '0;
               root_in  = '0;
               state_in = NM_SQRT;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         NM_SQRT: begin
            if (sr >= trial) begin
               srem_in = 18'(sr - trial);
               root_in = {root_ff[13:0], 1'b1};
            end else begin
               srem_in = sr[17:0];
               root_in = {root_ff[13:0], 1'b0};
            end
            q_in = {q_ff[27:0], 2'b00};
            if (cnt_ff == 5'd0) begin
               done_in  = 1'b1;
               state_in = NM_IDLE;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         default: state_in = NM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NM_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      d_ff    <= d_in;
      lsb_ff  <= lsb_in;
      q_ff    <= q_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
   end

endmodule

FILE: rtl/hbs_back.sv
// Back part: grid memory, four-tap read, shared MAC and normal sequencing.
module hbs_back import hbs_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_LENGTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_not_empty,
   input  hbs_entry_type       q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   output logic signed [15:0]  rsp_height,
   output logic signed [15:0]  rsp_normal_x,
   output logic [14:0]         rsp_normal_y,
   output logic signed [15:0]  rsp_normal_z
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_LENGTH);
   localparam int AW    = CW + RW;
   localparam int DEPTH = 1 << AW;

   logic signed [15:0] mem [DEPTH];
   logic signed [15:0] rd_data_ff;
   logic [AW-1:0]      addr;
   logic               mem_we;

   hbs_bk_state_type state_ff, state_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [1:0]  comp_ff, comp_in;
   logic        launched_ff, launched_in;
   logic [8:0]  col0_ff, col0_in, col1_ff, col1_in;
   logic [8:0]  row0_ff, row0_in, row1_ff, row1_in;
   logic [7:0]  fs_ff, fs_in, ft_ff, ft_in;
   logic signed [15:0] tl_ff, tl_in, tr_ff, tr_in, bl_ff, bl_in, br_ff, br_in;
   logic signed [25:0] top_ff, top_in, bot_ff, bot_in;
   logic signed [43:0] acc_ff, acc_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] dsq_ff, dsq_in, dtq_ff, dtq_in;
   logic [14:0] mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_height_ff, rsp_height_in;
   logic [15:0] rsp_nx_ff, rsp_nx_in, rsp_nz_ff, rsp_nz_in;
   logic [14:0] rsp_ny_ff, rsp_ny_in;

   logic signed [16:0] ds, dt;
   logic signed [25:0] mac_a;
   logic signed [17:0] mac_b;
   logic signed [43:0] prod;
   logic [8:0]  rfs, rft;
   logic [33:0] hsum;
   logic        nm_start, nm_done;
   logic [31:0] nm_sq;
   logic [14:0] nm_root;
   logic [8:0]  rd_col, rd_row;

   hbs_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (nm_start),
      .sq    (nm_sq),
      .len2  (acc_ff[33:0]),
      .done  (nm_done),
      .root  (nm_root)
   );

   assign ds   = 17'(tr_ff) - 17'(tl_ff);
   assign dt   = 17'(bl_ff) - 17'(tl_ff);
   assign rfs  = Q8_ONE - {1'b0, fs_ff};
   assign rft  = Q8_ONE - {1'b0, ft_ff};
   assign prod = mac_a * mac_b;
   // round to nearest, ties up, then keep Q8.8
   assign hsum = acc_ff[33:0] + 34'd32768;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_height   = rsp_height_ff;
   assign rsp_normal_x = rsp_nx_ff;
   assign rsp_normal_y = rsp_ny_ff;
   assign rsp_normal_z = rsp_nz_ff;

   assign nm_start = (state_ff == BK_NORM) && !launched_ff;
   assign q_pop    = (state_ff == BK_IDLE) && q_not_empty;
   assign mem_we   = q_pop && !q_head.is_query && q_head.wr_ok;

   // Tap order: TL, TR, BL, BR
   always_comb begin
      rd_col = cnt_ff[0] ? col1_ff : col0_ff;
      rd_row = cnt_ff[1] ? row1_ff : row0_ff;
      if (state_ff == BK_IDLE) begin
         addr = {RW'(q_head.row0), CW'(q_head.col0)};
      end else begin
         addr = {RW'(rd_row), CW'(rd_col)};
      end
   end

   always_comb begin
      case (cnt_ff)
         3'd0: begin mac_a = 26'(tl_ff);  mac_b = $signed({9'd0, rfs}); end
         3'd1: begin mac_a = 26'(tr_ff);  mac_b = $signed({10'd0, fs_ff}); end
         3'd2: begin mac_a = 26'(bl_ff);  mac_b = $signed({9'd0, rfs}); end
         3'd3: begin mac_a = 26'(br_ff);  mac_b = $signed({10'd0, fs_ff}); end
         3'd4: begin mac_a = top_ff;      mac_b = $signed({9'd0, rft}); end
         3'd5: begin mac_a = bot_ff;      mac_b = $signed({10'd0, ft_ff}); end
         3'd6: begin mac_a = 26'(ds);     mac_b = 18'(ds); end
         default: begin mac_a = 26'(dt);  mac_b = 18'(dt); end
      endcase
   end

   always_comb begin
      case (comp_ff)
         2'd0:    nm_sq = dsq_ff;
         2'd1:    nm_sq = Y_SQ;
         default: nm_sq = dtq_ff;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      comp_in       = comp_ff;
      launched_in   = launched_ff;
      col0_in       = col0_ff;
      col1_in       = col1_ff;
      row0_in       = row0_ff;
      row1_in       = row1_ff;
      fs_in         = fs_ff;
      ft_in         = ft_ff;
      tl_in         = tl_ff;
      tr_in         = tr_ff;
      bl_in         = bl_ff;
      br_in         = br_ff;
      top_in        = top_ff;
      bot_in        = bot_ff;
      acc_in        = acc_ff;
      height_in     = height_ff;
      dsq_in        = dsq_ff;
      dtq_in        = dtq_ff;
      mag_x_in      = mag_x_ff;
      mag_y_in      = mag_y_ff;
      rsp_valid_in  = 1'b0;
      rsp_height_in = rsp_height_ff;
      rsp_nx_in     = rsp_nx_ff;
      rsp_ny_in     = rsp_ny_ff;
      rsp_nz_in     = rsp_nz_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_pop && q_head.is_query) begin
               col0_in  = q_head.col0;
               col1_in  = q_head.col1;
               row0_in  = q_head.row0;
               row1_in  = q_head.row1;
               fs_in    = q_head.fs;
               ft_in    = q_head.ft;
               cnt_in   = 3'd0;
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            // read data is registered, so it arrives in the cycle after its address
            case (cnt_ff)
               3'd1:    tl_in = rd_data_ff;
               3'd2:    tr_in = rd_data_ff;
               3'd3:    bl_in = rd_data_ff;
               3'd4:    br_in = rd_data_ff;
               default: ;
            endcase
            if (cnt_ff == 3'd4) begin
               cnt_in   = 3'd0;
               state_in = BK_MAC;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         BK_MAC: begin
            case (cnt_ff)
               3'd1:    top_in = 26'(acc_ff + prod);
               3'd3:    bot_in = 26'(acc_ff + prod);
               3'd5:    acc_in = acc_ff + prod;
               3'd6: begin
                  height_in = hsum[31:16];
                  dsq_in    = prod[31:0];
                  acc_in    = prod;
               end
               3'd7: begin
                  dtq_in = prod[31:0];
                  acc_in = acc_ff + prod + 44'(LEN_BIAS);
               end
               default: acc_in = prod;
            endcase
            if (cnt_ff == 3'd7) begin
               comp_in     = 2'd0;
               launched_in = 1'b0;
               state_in    = BK_NORM;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         BK_NORM: begin
            if (nm_start) begin
               launched_in = 1'b1;
            end
            if (nm_done) begin
               launched_in = 1'b0;
               comp_in     = comp_ff + 2'd1;
               case (comp_ff)
                  2'd0: mag_x_in = nm_root;
                  2'd1: mag_y_in = nm_root;
                  default: begin
                     // component sign is opposite to the slope's
                     rsp_valid_in  = 1'b1;
                     rsp_height_in = height_ff;
                     rsp_ny_in     = mag_y_ff;
                     rsp_nx_in     = (!ds[16] && ds != 17'sd0) ?
                                     16'd0 - {1'b0, mag_x_ff} : {1'b0, mag_x_ff};
                     rsp_nz_in     = (!dt[16] && dt != 17'sd0) ?
                                     16'd0 - {1'b0, nm_root} : {1'b0, nm_root};
                     state_in      = BK_IDLE;
                  end
               endcase
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         comp_ff      <= '0;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         comp_ff      <= comp_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col0_ff       <= col0_in;
      col1_ff       <= col1_in;
      row0_ff       <= row0_in;
      row1_ff       <= row1_in;
      fs_ff         <= fs_in;
      ft_ff         <= ft_in;
      tl_ff         <= tl_in;
      tr_ff         <= tr_in;
      bl_ff         <= bl_in;
      br_ff         <= br_in;
      top_ff        <= top_in;
      bot_ff        <= bot_in;
      acc_ff        <= acc_in;
      height_ff     <= height_in;
      dsq_ff        <= dsq_in;
      dtq_ff        <= dtq_in;
      mag_x_ff      <= mag_x_in;
      mag_y_ff      <= mag_y_in;
      rsp_height_ff <= rsp_height_in;
      rsp_nx_ff     <= rsp_nx_in;
      rsp_ny_ff     <= rsp_ny_in;
      rsp_nz_ff     <= rsp_nz_in;
   end

   // single-port grid store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= q_head.wdata;
      end
      rd_data_ff <= mem[addr];
   end

endmodule

FILE: rtl/heightfield_bilinear_sampler.sv
// Top level of the heightfield bilinear sampler.
//
//   channel | ports                         | beat taken when
//   --------+-------------------------------+-------------------------
//   request | start, busy, req_*            | start && !busy
//   result  | rsp_valid, rsp_*              | rsp_valid (one cycle)
//   config  | csr_valid, csr_ready, csr_*   | csr_valid && csr_ready
//
// A write beat is stored the cycle after acceptance when the back end is idle.
// A query runs the four single-port grid reads, then the shared multiplier,
// then three passes through the bit-serial divide and square root unit, which
// sets the query rate. Synchronous active-high reset clears the queue and
// sequencers; grid contents are not cleared. Beats queue while the back end
// works; busy rises only when the two-entry queue is full. Results cannot be
// stalled.
module heightfield_bilinear_sampler import hbs_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_LENGTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   // request
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_cmd,
   input  logic [7:0]           req_col,
   input  logic [7:0]           req_row,
   input  logic signed [15:0]   req_height_value,
   input  logic signed [16:0]   req_pos_x,
   input  logic signed [16:0]   req_pos_z,
   // result
   output logic                 rsp_valid,
   output logic signed [15:0]   rsp_height,
   output logic signed [15:0]   rsp_normal_x,
   output logic [14:0]          rsp_normal_y,
   output logic signed [15:0]   rsp_normal_z,
   // config
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [8:0]           csr_wdata
);

   logic          q_full;
   logic          push;
   hbs_entry_type push_entry;
   logic          pop;
   logic          not_empty;
   hbs_entry_type head;

   // front may take a beat whenever the queue has room
   assign busy = q_full;

   hbs_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_LENGTH (MAX_LENGTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .start            (start),
      .queue_full       (q_full),
      .req_cmd          (req_cmd),
      .req_col          (req_col),
      .req_row          (req_row),
      .req_height_value (req_height_value),
      .req_pos_x        (req_pos_x),
      .req_pos_z        (req_pos_z),
      .push             (push),
      .push_entry       (push_entry)
   );

   hbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   // back end keeps order, so writes and queries never pass each other
   hbs_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_LENGTH (MAX_LENGTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_not_empty  (not_empty),
      .q_head       (head),
      .q_pop        (pop),
      .rsp_valid    (rsp_valid),
      .rsp_height   (rsp_height),
      .rsp_normal_x (rsp_normal_x),
      .rsp_normal_y (rsp_normal_y),
      .rsp_normal_z (rsp_normal_z)
   );

endmodule

FILE: rtl/hbs_checker.sv
// Port-level assertions for the sampler, bound to the top level.
module hbs_checker (
   input logic               clock,
   input logic               reset,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [15:0] rsp_normal_x,
   input logic [14:0]        rsp_normal_y,
   input logic signed [15:0] rsp_normal_z
);

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("busy or result after reset");

   a_single_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held two cycles");

   a_ny_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_y != 15'd0 && rsp_normal_y <= 15'd16384))
      else $error("normal y out of range");

   a_nxz_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x >= -16'sd16384 && rsp_normal_x <= 16'sd16384 &&
                     rsp_normal_z >= -16'sd16384 && rsp_normal_z <= 16'sd16384))
      else $error("normal x or z out of range");

endmodule

bind heightfield_bilinear_sampler hbs_checker u_hbs_checker (
   .clock        (clock),
   .reset        (reset),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_normal_x (rsp_normal_x),
   .rsp_normal_y (rsp_normal_y),
   .rsp_normal_z (rsp_normal_z)
);

FILE: sim/testbench.sv
// Self-checking testbench for heightfield_bilinear_sampler: directed table plus random traffic.
module testbench import hbs_pkg::*; ();

   localparam int HALF_PERIOD = 5;
   localparam int WATCHDOG_LIMIT = 4000;
   // Wait well past the back end's query time when idling.
   localparam int SETTLE_CYCLES = 400;
   localparam int ITEMS_PER_PHASE = 225;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct {
      logic signed [15:0] height;
      logic signed [15:0] nx;
      logic [14:0]        ny;
      logic signed [15:0] nz;
   } sample_type;

   typedef struct {
      logic        cmd;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [15:0] hval;
      logic [16:0] px;
      logic [16:0] pz;
      bit          typed;   // expected result typed in below
      sample_type  want;
   } dir_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_cmd = CMD_WRITE;
   logic [7:0]         req_col = '0;
   logic [7:0]         req_row = '0;
   logic signed [15:0] req_height_value = '0;
   logic signed [16:0] req_pos_x = '0;
   logic signed [16:0] req_pos_z = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_height;
   logic signed [15:0] rsp_normal_x;
   logic [14:0]        rsp_normal_y;
   logic signed [15:0] rsp_normal_z;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_GRID_WIDTH;
   logic [8:0]         csr_wdata = '0;

   // Testbench copy of the block state
   logic signed [15:0] height_copy [65536];
   bit                 cell_written [65536];
   int                 cols_in_use = 256;
   int                 rows_in_use = 256;

   sample_type         pending_samples [$];
   int                 mismatches = 0;
   int                 items_sent = 0;
   int                 idle_cycles = 0;
   int                 burst_left = 0;

   heightfield_bilinear_sampler dut (.*);

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v = v - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   // magnitude of one normal component in Q1.14
   function automatic longint unsigned normal_mag(longint c, longint unsigned len_sq);
      longint unsigned m;
      m = (c < 0) ? -c : c;
      return int_sqrt(((m * m) << 28) / len_sq);
   endfunction

   function automatic void map_axis(int pos, int n, output int idx, output int frac);
      int s;
      s = pos + ((n >> 1) << 8);
      if (s < 0) begin
         idx = 0; frac = 0;
      end else if ((s >> 8) >= n) begin
         idx = n - 1; frac = 0;
      end else begin
         idx = s >> 8; frac = s & 255;
      end
   endfunction

   // cell addresses read by a query: top-left, top-right, bottom-left, bottom-right
   function automatic void query_cells(logic [16:0] px, logic [16:0] pz, output int addr [4],
                                       output int fs, output int ft);
      int si, ti, s1, t1;
      map_axis(int'($signed(px)), cols_in_use, si, fs);
      map_axis(int'($signed(pz)), rows_in_use, ti, ft);
      s1 = (si + 1 < cols_in_use) ? si + 1 : si;
      t1 = (ti + 1 < rows_in_use) ? ti + 1 : ti;
      addr[0] = ti * 256 + si;
      addr[1] = ti * 256 + s1;
      addr[2] = t1 * 256 + si;
      addr[3] = t1 * 256 + s1;
   endfunction

   function automatic sample_type sample_terrain(logic [16:0] px, logic [16:0] pz);
      int addr [4];
      int fs, ft;
      longint tl, tr, bl, br, acc, ds, dt;
      longint unsigned len_sq, mag;
      sample_type r;
      query_cells(px, pz, addr, fs, ft);
      tl = height_copy[addr[0]];
      tr = height_copy[addr[1]];
      bl = height_copy[addr[2]];
      br = height_copy[addr[3]];
      acc = tl * (256 - fs) * (256 - ft) + tr * fs * (256 - ft)
          + bl * (256 - fs) * ft + br * fs * ft;
      acc = (acc + 32768) >>> 16;   // round to nearest, ties up
      r.height = acc[15:0];
      ds = tr - tl;
      dt = bl - tl;
      len_sq = ds * ds + dt * dt + 65536;
      mag = normal_mag(ds, len_sq);
      r.nx = (ds > 0) ? -mag[15:0] : mag[15:0];
      r.ny = normal_mag(256, len_sq) & 15'h7FFF;
      mag = normal_mag(dt, len_sq);
      r.nz = (dt > 0) ? -mag[15:0] : mag[15:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- result check

   always @(posedge clock) begin
      sample_type w;
      if (!reset && rsp_valid) begin
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: height %0d", rsp_height);
         end else begin
            w = pending_samples.pop_front();
            if (rsp_height !== w.height || rsp_normal_x !== w.nx ||
                rsp_normal_y !== w.ny || rsp_normal_z !== w.nz) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp h=%0d n=(%0d,%0d,%0d) got h=%0d n=(%0d,%0d,%0d)",
                           w.height, w.nx, w.ny, w.nz, rsp_height, rsp_normal_x,
                           rsp_normal_y, rsp_normal_z);
            end
         end
      end
   end

   // watchdog: cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("heightfield_bilinear_sampler regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- drivers

   // Present one beat and hold until taken; start stays high into a following beat within a burst.
   task automatic drive_beat(logic cmd, logic [7:0] col, logic [7:0] row, logic [15:0] hval,
                             logic [16:0] px, logic [16:0] pz, bit typed, sample_type want);
      start <= 1'b1;
      req_cmd <= cmd;
      req_col <= col;
      req_row <= row;
      req_height_value <= hval;
      req_pos_x <= px;
      req_pos_z <= pz;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (cmd == CMD_WRITE) begin
         height_copy[{row, col}] = hval;
         cell_written[{row, col}] = 1'b1;
      end else begin
         pending_samples.push_back(typed ? want : sample_terrain(px, pz));
      end
      // sender bursts: random gap once the burst runs out
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 2) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   endtask

   // Queries only touch written cells: fill any missing neighbor first.
   task automatic issue_query(logic [16:0] px, logic [16:0] pz, bit typed, sample_type want);
      int addr [4];
      int fs, ft;
      query_cells(px, pz, addr, fs, ft);
      foreach (addr[i])
         if (!cell_written[addr[i]])
            drive_beat(CMD_WRITE, addr[i][7:0], addr[i][15:8], 16'($urandom), '0, '0, 0, want);
      drive_beat(CMD_QUERY, '0, '0, '0, px, pz, typed, want);
   endtask

   // Wait out all results plus the tail of any write still in flight.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [8:0] value);
      int sat;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sat = (value == 0) ? 1 : (value > 256) ? 256 : int'(value);
      if (idx == CSR_GRID_WIDTH) cols_in_use = sat;
      else if (idx == CSR_GRID_LENGTH) rows_in_use = sat;
   endtask

   // ---------------------------------------------------------------- stimulus

   initial begin
      dir_row_type dir_rows [];
      sample_type flat_256, flat_max, none;
      int phase_end, s;
      logic [8:0] wset [6][2];
      logic [16:0] px, pz;

      flat_256 = '{16'sd256, 16'sd0, 15'd16384, 16'sd0};
      flat_max = '{16'sd32767, 16'sd0, 15'd16384, 16'sd0};
      none = '{'0, '0, '0, '0};
      // Positions use the reset grid of 256 x 256: -32768 lands on cell 0.
      dir_rows = '{
         '{CMD_WRITE, 8'd0,   8'd0,   16'd256,    '0,          '0,          0, none},
         '{CMD_WRITE, 8'd1,   8'd0,   16'd256,    '0,          '0,          0, none},
         '{CMD_WRITE, 8'd0,   8'd1,   16'd256,    '0,          '0,          0, none},
         '{CMD_WRITE, 8'd1,   8'd1,   16'd256,    '0,          '0,          0, none},
         '{CMD_QUERY, 8'd0,   8'd0,   16'd0,      -17'sd32768, -17'sd32768, 1, flat_256},
         // most negative position (-65536): shifted coordinate below zero, cell 0, no offset
         '{CMD_QUERY, 8'd0,   8'd0,   16'd0,      17'h1_0000,  17'h1_0000,  1, flat_256},
         '{CMD_WRITE, 8'd255, 8'd255, 16'h7FFF,   '0,          '0,          0, none},
         // past the far corner: clamped, neighbor duplicated
         '{CMD_QUERY, 8'd0,   8'd0,   16'd0,      17'sd65535,  17'sd65535,  1, flat_max},
         '{CMD_WRITE, 8'd128, 8'd128, 16'h8000,   '0,          '0,          0, none},
         '{CMD_WRITE, 8'd129, 8'd128, 16'h7FFF,   '0,          '0,          0, none},
         '{CMD_WRITE, 8'd128, 8'd129, 16'h8000,   '0,          '0,          0, none},
         '{CMD_WRITE, 8'd129, 8'd129, 16'h0000,   '0,          '0,          0, none},
         '{CMD_QUERY, 8'd0,   8'd0,   16'd0,      17'sd0,      17'sd0,      0, none},
         '{CMD_QUERY, 8'd0,   8'd0,   16'd0,      17'sd128,    17'sd128,    0, none},
         '{CMD_QUERY, 8'd0,   8'd0,   16'd0,      17'sd255,    17'sd255,    0, none},
         '{CMD_QUERY, 8'd0,   8'd0,   16'd0,      17'sd255,    17'sd0,      0, none},
         '{CMD_QUERY, 8'd0,   8'd0,   16'd0,      17'sd0,      17'sd255,    0, none}
      };

      // grid settings per random phase; zero and out-of-range values saturate
      wset = '{'{9'd256, 9'd256}, '{9'd1, 9'd1}, '{9'd2, 9'd255},
               '{9'd511, 9'd0}, '{9'd0, 9'd3}, '{9'd256, 9'd256}};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].cmd == CMD_QUERY)
            issue_query(dir_rows[i].px, dir_rows[i].pz, dir_rows[i].typed, dir_rows[i].want);
         else
            drive_beat(CMD_WRITE, dir_rows[i].col, dir_rows[i].row, dir_rows[i].hval,
                       '0, '0, 0, none);
      end

      for (int ph = 0; ph < 6; ph++) begin
         settle();
         write_csr(CSR_GRID_WIDTH, (ph == 5) ? 9'($urandom_range(1, 256)) : wset[ph][0]);
         write_csr(CSR_GRID_LENGTH, (ph == 5) ? 9'($urandom_range(1, 256)) : wset[ph][1]);
         if (ph == 2) begin
            // spare indexes must not disturb the grid size
            write_csr(CSR_SPARE_2, 9'd7);
            write_csr(CSR_SPARE_3, 9'd511);
         end
         phase_end = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) begin
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  // write near the grid in use, sometimes anywhere
                  if ($urandom_range(0, 3) == 0)
                     drive_beat(CMD_WRITE, 8'($urandom), 8'($urandom), 16'($urandom),
                                '0, '0, 0, none);
                  else
                     drive_beat(CMD_WRITE, 8'($urandom_range(0, cols_in_use - 1)),
                                8'($urandom_range(0, rows_in_use - 1)), 16'($urandom),
                                '0, '0, 0, none);
               end
               3: begin
                  issue_query(17'($urandom), 17'($urandom), 0, none);
               end
               default: begin
                  s = $urandom_range(0, (cols_in_use + 1) * 256) - 128;
                  px = 17'(s - ((cols_in_use >> 1) << 8));
                  s = $urandom_range(0, (rows_in_use + 1) * 256) - 128;
                  pz = 17'(s - ((rows_in_use >> 1) << 8));
                  issue_query(px, pz, 0, none);
               end
            endcase
            // now and then drain the result path completely
            if ($urandom_range(0, 60) == 0) begin
               start <= 1'b0;
               @(posedge clock);
               while (pending_samples.size() != 0) @(posedge clock);
            end
         end
      end

      settle();
      if (mismatches == 0 && pending_samples.size() == 0) begin
         $display("heightfield_bilinear_sampler regression: pass");
      end else begin
         $display("heightfield_bilinear_sampler regression: fail");
      end
      $finish;
   end

endmodule
